>>> design/pspool_pkg.sv
// Shared constants and width helpers for the particle slot pool.
`default_nettype none
package pspool_pkg;

  localparam int SLOTS_DEF     = 1024;
  localparam int TIME_BITS_DEF = 32;
  localparam int DEATH_W       = 32;
  localparam int ELAPSED_W     = 16;
  localparam int INTERVAL_W    = 16;
  localparam int CTIME_W       = 32;
  localparam int ACTION_W      = 2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

  // Slot number width.
  function automatic int idx_w(input int slots);
    return $clog2(slots);
  endfunction

  // Width of a count that can hold the slot total itself.
  function automatic int cnt_w(input int slots);
    return $clog2(slots + 1);
  endfunction

  // Result beat width, padded to whole bytes.
  function automatic int out_tdata_w(input int slots);
    int raw;
    raw = 3 * idx_w(slots) + cnt_w(slots) + 2 + CTIME_W;
    return ((raw + 7) / 8) * 8;
  endfunction

endpackage
`default_nettype wire

>>> design/pspool_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module pspool_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/particle_slot_pool_with_lifetime_sweep.sv
// Particle slot pool: free-slot stack, death-time store and round-robin expiry sweep.
// Flow: flush, unknown action and an add on an empty pool finish in the accepting cycle and
// their beat is registered into the output register; an add first reads the free stack top,
// then writes the slot in ST_ADD. A tick visits visited = min(SLOTS, elapsed*SLOTS/interval)
// slots, one slot per cycle through the slot memory read port, then waits for the last read
// and finishes. A finished result waits in ST_RESP while the output is busy. One item at a time.
// Reset: a clearing pass over all SLOTS slots marks every slot dead and loads the free stack;
// no item is accepted during it, configuration writes are taken throughout.
`default_nettype none
module particle_slot_pool_with_lifetime_sweep
  import pspool_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration: full_sweep_interval
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [INTERVAL_W-1:0]             cfg_data,
  // input beat
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // tdata: death_time [31:0], elapsed [47:32]
  input  wire logic [DEATH_W+ELAPSED_W-1:0]      s_tdata,
  // tuser: action [1:0]
  input  wire logic [ACTION_W-1:0]               s_tuser,
  // result beat
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // tdata: slot_index, pool_full, freed_count, dirty_valid, dirty_begin, dirty_end,
  //        current_time, zero pad
  output logic [out_tdata_w(SLOTS)-1:0]          m_tdata
);

  localparam int IDX_W   = idx_w(SLOTS);
  localparam int CNT_W   = cnt_w(SLOTS);
  localparam int RES_W   = 3 * IDX_W + CNT_W + 2 + CTIME_W;
  localparam int OUT_W   = out_tdata_w(SLOTS);
  localparam int PROD_W  = ELAPSED_W + CNT_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int SM_W    = DEATH_W + 1;
  localparam int CMP_W   = (TIME_BITS > DEATH_W) ? TIME_BITS : DEATH_W;

  localparam logic [CNT_W-1:0] SLOTS_C   = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]            state;
  logic [IDX_W-1:0]      init_addr;
  logic [INTERVAL_W-1:0] interval;
  logic [CNT_W-1:0]      free_count;
  logic [IDX_W-1:0]      sweep_pos;
  logic [TIME_BITS-1:0]  time_now;
  logic                  dirty_flag;
  logic [IDX_W-1:0]      dirty_low;
  logic [IDX_W-1:0]      dirty_high;
  logic [DEATH_W-1:0]    death_hold;
  logic [PROD_W-1:0]     prod;
  logic [ACC_W-1:0]      acc;
  logic [CNT_W-1:0]      sweep_k;
  logic [CNT_W-1:0]      freed;
  logic                  rd_pend;
  logic [IDX_W-1:0]      rd_addr;
  logic [RES_W-1:0]      res_hold;
  logic [RES_W-1:0]      out_data;

  // slot memory: {dead, death_time}
  logic                  sm_we;
  logic [IDX_W-1:0]      sm_waddr;
  logic [SM_W-1:0]       sm_wdata;
  logic [SM_W-1:0]       sm_rdata;
  // free stack memory
  logic                  fs_we;
  logic [IDX_W-1:0]      fs_waddr;
  logic [IDX_W-1:0]      fs_wdata;
  logic [IDX_W-1:0]      fs_raddr;
  logic [IDX_W-1:0]      fs_rdata;

  logic                  s_fire;
  logic                  out_free;
  logic [ACTION_W-1:0]   action;
  logic [DEATH_W-1:0]    in_death;
  logic [ELAPSED_W-1:0]  in_elapsed;
  logic [INTERVAL_W-1:0] interval_eff;
  logic                  issue;
  logic                  expire;
  logic                  done;
  logic [RES_W-1:0]      done_vec;
  logic [CNT_W-1:0]      top_ptr;

  logic [IDX_W-1:0]      r_slot;
  logic                  r_full;
  logic [CNT_W-1:0]      r_freed;
  logic                  r_dv;
  logic [IDX_W-1:0]      r_db;
  logic [IDX_W-1:0]      r_de;

  assign action       = s_tuser;
  assign in_death     = s_tdata[DEATH_W-1:0];
  assign in_elapsed   = s_tdata[DEATH_W+ELAPSED_W-1:DEATH_W];
  assign s_tready     = (state == ST_IDLE);
  assign s_fire       = s_tvalid && s_tready;
  assign cfg_ready    = 1'b1;
  assign out_free     = !m_tvalid || m_tready;
  assign interval_eff = (interval == '0) ? INTERVAL_W'(1) : interval;
  assign top_ptr      = free_count - CNT_W'(1);
  assign fs_raddr     = top_ptr[IDX_W-1:0];
  assign m_tdata      = OUT_W'(out_data);

  assign issue  = (state == ST_SWEEP) && (sweep_k < SLOTS_C) && (acc <= ACC_W'(prod));
  assign expire = rd_pend && !sm_rdata[DEATH_W] &&
                  (CMP_W'(sm_rdata[DEATH_W-1:0]) <= CMP_W'(time_now));

  // Memory port steering.
  always_comb begin
    sm_we    = 1'b0;
    sm_waddr = rd_addr;
    sm_wdata = {1'b1, sm_rdata[DEATH_W-1:0]};
    fs_we    = 1'b0;
    fs_waddr = free_count[IDX_W-1:0];
    fs_wdata = rd_addr;
    unique case (state)
      ST_INIT: begin
        sm_we    = 1'b1;
        sm_waddr = init_addr;
        sm_wdata = {1'b1, {DEATH_W{1'b0}}};
        fs_we    = 1'b1;
        fs_waddr = init_addr;
        fs_wdata = init_addr;
      end
      ST_ADD: begin
        sm_we    = 1'b1;
        sm_waddr = fs_rdata;
        sm_wdata = {1'b0, death_hold};
      end
      ST_SWEEP: begin
        // mark dead and push back as free
        sm_we = expire;
        fs_we = expire && (free_count < SLOTS_C);
      end
      default: begin
      end
    endcase
  end

  // Result assembly for the cycle in which an item finishes.
  always_comb begin
    done    = 1'b0;
    r_slot  = '0;
    r_full  = 1'b0;
    r_freed = '0;
    r_dv    = 1'b0;
    r_db    = '0;
    r_de    = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          priority if (action == ACT_ADD) begin
            done   = (free_count == '0);
            r_full = 1'b1;
          end else if (action == ACT_FLUSH) begin
            done = 1'b1;
            r_dv = dirty_flag;
            r_db = dirty_flag ? dirty_low : '0;
            r_de = dirty_flag ? dirty_high : '0;
          end else if (action == ACT_TICK) begin
            done = 1'b0;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_ADD: begin
        done   = 1'b1;
        r_slot = fs_rdata;
      end
      ST_SWEEP: begin
        done    = !issue && !rd_pend;
        r_freed = freed;
      end
      ST_RESP: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
    done_vec = (state == ST_RESP) ? res_hold :
               {CTIME_W'(time_now), r_de, r_db, r_dv, r_freed, r_full, r_slot};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      init_addr  <= '0;
      interval   <= INTERVAL_RESET;
      free_count <= SLOTS_C;
      sweep_pos  <= '0;
      time_now   <= '0;
      dirty_flag <= 1'b1;
      dirty_low  <= '0;
      dirty_high <= LAST_SLOT;
      rd_pend    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        interval <= cfg_data;
      end

      if (out_free && done) begin
        m_tvalid <= 1'b1;
        out_data <= done_vec;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      rd_pend <= issue;
      rd_addr <= sweep_pos;

      if (done) begin
        if (out_free) begin
          state <= ST_IDLE;
        end else begin
          state    <= ST_RESP;
          res_hold <= done_vec;
        end
      end

      unique case (state)
        ST_INIT: begin
          init_addr <= init_addr + IDX_W'(1);
          if (init_addr == LAST_SLOT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            if (action == ACT_ADD && free_count != '0) begin
              death_hold <= in_death;
              state      <= ST_ADD;
            end else if (action == ACT_TICK) begin
              time_now <= time_now + TIME_BITS'(in_elapsed);
              prod     <= PROD_W'(in_elapsed) * PROD_W'(SLOTS);
              acc      <= ACC_W'(interval_eff);
              sweep_k  <= '0;
              freed    <= '0;
              state    <= ST_SWEEP;
            end else if (action == ACT_FLUSH) begin
              dirty_flag <= 1'b0;
            end
          end
        end
        ST_ADD: begin
          free_count <= free_count - CNT_W'(1);
          if (dirty_flag) begin
            if (fs_rdata < dirty_low) begin
              dirty_low <= fs_rdata;
            end
            if (fs_rdata > dirty_high) begin
              dirty_high <= fs_rdata;
            end
          end else begin
            dirty_flag <= 1'b1;
            dirty_low  <= fs_rdata;
            dirty_high <= fs_rdata;
          end
        end
        ST_SWEEP: begin
          // one visit per cycle while k < SLOTS and (k+1)*interval <= elapsed*SLOTS
          if (issue) begin
            sweep_pos <= (sweep_pos == LAST_SLOT) ? '0 : sweep_pos + IDX_W'(1);
            acc       <= acc + ACC_W'(interval_eff);
            sweep_k   <= sweep_k + CNT_W'(1);
          end
          if (expire) begin
            freed <= freed + CNT_W'(1);
            if (free_count < SLOTS_C) begin
              free_count <= free_count + CNT_W'(1);
            end
          end
        end
        ST_RESP: begin
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  pspool_ram #(
    .WIDTH (SM_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sweep_pos),
    .rdata (sm_rdata)
  );

  pspool_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

`ifndef NO_ASSERTIONS
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= SLOTS_C)
    else $error("free count above pool size");

  a_add_pops: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD |=> free_count == $past(free_count) - CNT_W'(1))
    else $error("add did not pop exactly one slot");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> sweep_k <= SLOTS_C && freed <= sweep_k)
    else $error("sweep visited or freed too many slots");

  a_read_in_sweep: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == ST_SWEEP)
    else $error("slot read returned outside the sweep");

  a_dirty_order: assert property (@(posedge clk) disable iff (rst)
    dirty_flag |-> dirty_low <= dirty_high)
    else $error("dirty range inverted");
`endif

endmodule
`default_nettype wire

>>> dv/slot_pool_checker.sv
// Checker for the particle slot pool: tracks the pool state, predicts every result beat and compares.
module slot_pool_checker
  import pspool_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [INTERVAL_W-1:0]        cfg_data,
  input  wire logic                         s_tvalid,
  input  wire logic                         s_tready,
  // tdata: death_time [31:0], elapsed [47:32]
  input  wire logic [DEATH_W+ELAPSED_W-1:0] s_tdata,
  // tuser: action [1:0]
  input  wire logic [ACTION_W-1:0]          s_tuser,
  input  wire logic                         m_tvalid,
  input  wire logic                         m_tready,
  // tdata: slot_index, pool_full, freed_count, dirty_valid, dirty_begin, dirty_end,
  //        current_time, zero pad
  input  wire logic [out_tdata_w(SLOTS_DEF)-1:0] m_tdata,
  output int                                mismatch_total,
  output int                                awaited
);

  localparam int NSLOT = SLOTS_DEF;
  localparam int OUT_W = out_tdata_w(SLOTS_DEF);

  // Result beat layout, last member in the lowest bits.
  typedef struct packed {
    logic [CTIME_W-1:0] ctime;
    logic [9:0]         dend;
    logic [9:0]         dbeg;
    logic               dval;
    logic [10:0]        freed;
    logic               full;
    logic [9:0]         slot;
  } pool_result_t;

  localparam int RES_W = $bits(pool_result_t);

  logic [INTERVAL_W-1:0] interval;
  logic [DEATH_W-1:0]    death_mem [NSLOT];
  logic                  dead_mark [NSLOT];
  logic [9:0]            free_stk  [NSLOT];
  logic [10:0]           n_free;
  logic [9:0]            sweep_pos;
  logic [CTIME_W-1:0]    now;
  logic                  dirty_any;
  logic [9:0]            dirty_lo;
  logic [9:0]            dirty_hi;

  pool_result_t awaited_results [$];
  int errors = 0;

  assign mismatch_total = errors;

  task automatic clear_pool();
    interval = INTERVAL_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      death_mem[i] = '0;
      dead_mark[i] = 1'b1;
      free_stk[i]  = 10'(i);
    end
    n_free    = 11'(NSLOT);
    sweep_pos = '0;
    now       = '0;
    dirty_any = 1'b1;
    dirty_lo  = '0;
    dirty_hi  = 10'(NSLOT - 1);
    awaited_results.delete();
  endtask

  function automatic pool_result_t next_pool_result(input logic [ACTION_W-1:0] act,
                                                    input logic [DEATH_W-1:0] death,
                                                    input logic [ELAPSED_W-1:0] elap);
    pool_result_t res;
    logic [63:0]  visits;
    logic [9:0]   slot;
    res = '0;
    case (act)
      ACT_ADD: begin
        if (n_free == 0) begin
          res.full = 1'b1;
        end else begin
          slot = free_stk[n_free - 1'b1];
          n_free = n_free - 1'b1;
          death_mem[slot] = death;
          dead_mark[slot] = 1'b0;
          if (!dirty_any) begin
            dirty_any = 1'b1;
            dirty_lo  = slot;
            dirty_hi  = slot;
          end else begin
            if (slot < dirty_lo) dirty_lo = slot;
            if (slot > dirty_hi) dirty_hi = slot;
          end
          res.slot = slot;
        end
      end
      ACT_TICK: begin
        now = now + CTIME_W'(elap);
        // zero interval behaves as one
        visits = (64'(elap) * 64'(NSLOT)) / 64'((interval == 0) ? 1 : interval);
        if (visits > 64'(NSLOT)) visits = 64'(NSLOT);
        for (int k = 0; k < int'(visits); k++) begin
          if (!dead_mark[sweep_pos] && death_mem[sweep_pos] <= now) begin
            dead_mark[sweep_pos] = 1'b1;
            if (n_free < NSLOT) begin
              free_stk[n_free[9:0]] = sweep_pos;
              n_free = n_free + 1'b1;
            end
            res.freed = res.freed + 1'b1;
          end
          sweep_pos = sweep_pos + 1'b1;
        end
      end
      ACT_FLUSH: begin
        if (dirty_any) begin
          res.dval = 1'b1;
          res.dbeg = dirty_lo;
          res.dend = dirty_hi;
        end
        dirty_any = 1'b0;
      end
      default: ;
    endcase
    res.ctime = now;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pool_result_t want;
    pool_result_t got;
    if (rst) begin
      clear_pool();
    end else begin
      if (cfg_valid && cfg_ready) interval = cfg_data;
      // compare first: a beat leaving now belongs to an older item
      if (m_tvalid && m_tready) begin
        got = pool_result_t'(m_tdata[RES_W-1:0]);
        if (awaited_results.size() == 0) begin
          $error("result beat with no item pending: %h", m_tdata);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("slot_index", 32'(want.slot), 32'(got.slot));
          check_field("pool_full", 32'(want.full), 32'(got.full));
          check_field("freed_count", 32'(want.freed), 32'(got.freed));
          check_field("dirty_valid", 32'(want.dval), 32'(got.dval));
          check_field("dirty_begin", 32'(want.dbeg), 32'(got.dbeg));
          check_field("dirty_end", 32'(want.dend), 32'(got.dend));
          check_field("current_time", want.ctime, got.ctime);
          check_field("pad", 32'd0, 32'(m_tdata[OUT_W-1:RES_W]));
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(next_pool_result(s_tuser, s_tdata[DEATH_W-1:0],
                                                   s_tdata[DEATH_W +: ELAPSED_W]));
    end
    awaited <= awaited_results.size();
  end

endmodule

>>> dv/tb.sv
// Testbench top for the particle slot pool: clock, reset, stimulus and verdict.
module tb;
  import pspool_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int OUT_W = out_tdata_w(SLOTS_DEF);

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [INTERVAL_W-1:0]        cfg_data  = INTERVAL_RESET;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [DEATH_W+ELAPSED_W-1:0] s_tdata   = '0;
  logic [ACTION_W-1:0]          s_tuser   = ACT_ADD;
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [OUT_W-1:0]             m_tdata;

  int          fail_total;
  int          pending;
  bit          quiet    = 1'b0;
  logic [31:0] time_est = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  particle_slot_pool_with_lifetime_sweep #(
    .SLOTS     (SLOTS_DEF),
    .TIME_BITS (TIME_BITS_DEF)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  slot_pool_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_total (fail_total),
    .awaited        (pending)
  );

  // Result side: stall in bursts, hold ready high once quiet.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 18);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 12);
        m_tready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic write_interval(input logic [INTERVAL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Leave tvalid high after the beat; the next call or an idle replaces it.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [DEATH_W-1:0] death,
                           input logic [ELAPSED_W-1:0] elap);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {elap, death};
    if (act == ACT_TICK) time_est = time_est + 32'(elap);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_mixed(input int n, input int add_pct, input int tick_pct,
                           input int flush_pct, input int big_pct, input int life_max,
                           input int elap_max);
    int                   r;
    logic [DEATH_W-1:0]   death;
    logic [ELAPSED_W-1:0] elap;
    for (int i = 0; i < n; i++) begin
      r     = $urandom_range(0, 99);
      death = $urandom();
      elap  = 16'($urandom_range(0, 65535));
      if (r < add_pct) begin
        // mostly lifetimes near the current time so slots keep expiring
        if ($urandom_range(0, 19) != 0) death = time_est + 32'($urandom_range(0, life_max));
        send_item(ACT_ADD, death, elap);
      end else if (r < add_pct + tick_pct) begin
        if ($urandom_range(0, 99) >= big_pct) elap = 16'($urandom_range(0, elap_max));
        send_item(ACT_TICK, death, elap);
      end else if (r < add_pct + tick_pct + flush_pct) begin
        send_item(ACT_FLUSH, death, elap);
      end else begin
        send_item(ACT_UNUSED, death, elap);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_interval(INTERVAL_RESET);

    // reset range, empty flush, unused code, zero-count tick
    send_item(ACT_FLUSH, $urandom(), 16'($urandom()));
    send_item(ACT_FLUSH, $urandom(), 16'($urandom()));
    send_item(ACT_UNUSED, $urandom(), 16'($urandom()));
    send_item(ACT_TICK, $urandom(), 16'd0);
    send_item(ACT_ADD, 32'd0, 16'($urandom()));
    send_item(ACT_ADD, 32'hFFFF_FFFF, 16'($urandom()));
    send_item(ACT_ADD, 32'd5, 16'($urandom()));
    send_item(ACT_FLUSH, $urandom(), 16'($urandom()));
    send_item(ACT_TICK, $urandom(), 16'd1);
    send_item(ACT_TICK, $urandom(), 16'hFFFF);
    send_item(ACT_ADD, 32'd100, 16'($urandom()));
    send_item(ACT_FLUSH, $urandom(), 16'($urandom()));
    send_item(ACT_TICK, $urandom(), 16'd999);

    // shortest interval: every tick with nonzero elapsed sweeps the whole pool; expiry at equal time
    wait_results();
    write_interval(16'd1);
    send_item(ACT_TICK, $urandom(), 16'd1);
    send_item(ACT_ADD, time_est, 16'($urandom()));
    send_item(ACT_TICK, $urandom(), 16'd0);
    send_item(ACT_ADD, time_est + 32'd3, 16'($urandom()));
    send_item(ACT_TICK, $urandom(), 16'd3);

    wait_results();
    write_interval(16'd0);
    send_item(ACT_TICK, $urandom(), 16'd2);
    send_item(ACT_UNUSED, $urandom(), 16'($urandom()));

    wait_results();
    write_interval(16'hFFFF);
    send_item(ACT_TICK, $urandom(), 16'd64);
    send_item(ACT_TICK, $urandom(), 16'hFFFF);
    send_item(ACT_FLUSH, $urandom(), 16'($urandom()));

    // mixed traffic at the default interval, with a full pause halfway
    wait_results();
    write_interval(INTERVAL_RESET);
    run_mixed(150, 55, 28, 12, 10, 3000, 40);
    wait_results();
    run_mixed(150, 55, 28, 12, 10, 3000, 40);

    // fill the pool: slow sweep, nearly all adds, so adds get dropped
    wait_results();
    write_interval(16'($urandom_range(40000, 65535)));
    run_mixed(1100, 95, 3, 2, 0, 100000, 20);

    // drain it again with full sweeps and large steps
    wait_results();
    write_interval(16'd1);
    run_mixed(80, 40, 50, 10, 20, 300000, 30000);

    quiet = 1'b1;
    wait_results();
    write_interval(16'($urandom_range(2, 65534)));
    run_mixed(150, 50, 30, 15, 5, 5000, 60);

    wait_results();
    repeat (20) @(posedge clk);
    if (fail_total == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
design/pspool_pkg.sv
design/pspool_ram.sv
design/particle_slot_pool_with_lifetime_sweep.sv
dv/slot_pool_checker.sv
dv/tb.sv
